[hw/rtl/crc_pkg.sv]
// Shared types and constants for the chunk residency cache.
// Holds the slot entry and ring control structs; no dependencies.
`default_nettype none

package crc_pkg;

    // Default number of slots and fixed field widths.
    localparam int SLOTS_DEFAULT = 256;
    localparam int COORD_W       = 16;
    localparam int SLOT_W        = 8;

    // Input word opcodes.
    localparam logic OP_ACCESS    = 1'b0;
    localparam logic OP_FRAME_END = 1'b1;

    // One slot entry as it travels around the ring.
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               stored;
        logic               used;
    } slot_entry_t;

    // Controls broadcast from the head controller to every cell.
    typedef struct packed {
        logic shift_en;
        logic clear_used;
    } ring_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/crc_cell.sv]
// One slot cell of the rotating ring; passes its entry to its neighbor on shift.
// Depends on crc_pkg for the entry and control types.
`default_nettype none

module crc_cell
    import crc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire ring_ctl_t   ctl,
    input  wire slot_entry_t d,
    output slot_entry_t      q
);

    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] x_next;
    logic [COORD_W-1:0] y_reg;
    logic [COORD_W-1:0] y_next;
    logic               stored_reg;
    logic               stored_next;
    logic               used_reg;
    logic               used_next;

    // Take the neighbor's entry on shift; the frame end clears the used mark.
    always_comb
    begin
        x_next      = x_reg;
        y_next      = y_reg;
        stored_next = stored_reg;
        used_next   = used_reg;
        if (ctl.shift_en)
        begin
            x_next      = d.x;
            y_next      = d.y;
            stored_next = d.stored;
            used_next   = d.used;
        end
        else if (ctl.clear_used)
        begin
            used_next = 1'b0;
        end
    end

    // Marks are control state and reset to zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_reg <= 1'b0;
            used_reg   <= 1'b0;
        end
        else
        begin
            stored_reg <= stored_next;
            used_reg   <= used_next;
        end
    end

    // The position is only read once the stored mark is set.
    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
    end

    assign q.x      = x_reg;
    assign q.y      = y_reg;
    assign q.stored = stored_reg;
    assign q.used   = used_reg;

endmodule

`default_nettype wire

[hw/rtl/crc_ctrl.sv]
// Head controller: compares the entry at the ring head, picks the slot and writes it back.
// Depends on crc_pkg; drives the ring controls and the feedback entry into the last cell.
`default_nettype none

module crc_ctrl
    import crc_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               opcode,
    input  wire logic [COORD_W-1:0] pos_x,
    input  wire logic [COORD_W-1:0] pos_y,
    input  wire logic               changed,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [SLOT_W-1:0]       slot,
    output logic                    hit,
    output logic                    full_res,
    input  wire slot_entry_t        head_entry,
    output slot_entry_t             feedback,
    output ring_ctl_t               ctl
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
    localparam logic [IDX_W:0]   SLOTS_W  = (IDX_W + 1)'(SLOTS);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEARCH = 4'b0010,
        ST_WRITE  = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [IDX_W-1:0]   cnt_reg, cnt_next;
    logic [IDX_W-1:0]   next_slot_reg, next_slot_next;
    logic [COORD_W-1:0] x_reg, x_next;
    logic [COORD_W-1:0] y_reg, y_next;
    logic               chg_reg, chg_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   found_idx_reg, found_idx_next;
    logic               cand_reg, cand_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [IDX_W-1:0]   best_gap_reg, best_gap_next;
    logic               out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]  out_slot_reg, out_slot_next;
    logic               out_hit_reg, out_hit_next;
    logic               out_full_reg, out_full_next;

    logic [IDX_W-1:0]   head_inc;
    logic [IDX_W-1:0]   best_inc;
    logic               match;
    logic               eff_stored;
    logic               cand;
    logic [IDX_W:0]     gap_wide;
    logic [IDX_W-1:0]   gap;
    logic               do_hit;
    logic               do_claim;
    logic [IDX_W-1:0]   target;
    logic [EXT_W-1:0]   res_ext;

    // Compare the head entry against the chunk under search.
    always_comb
    begin
        head_inc   = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
        best_inc   = (best_idx_reg == LAST_IDX) ? '0 : best_idx_reg + 1'b1;
        match      = head_entry.stored && (head_entry.x == x_reg) && (head_entry.y == y_reg);
        eff_stored = head_entry.stored && !(match && chg_reg);
        cand       = !(eff_stored && head_entry.used);
        // Round-robin distance of the head slot from the claim pointer.
        if (head_reg >= next_slot_reg)
        begin
            gap_wide = {1'b0, head_reg} - {1'b0, next_slot_reg};
        end
        else
        begin
            gap_wide = {1'b0, head_reg} + SLOTS_W - {1'b0, next_slot_reg};
        end
        gap = gap_wide[IDX_W-1:0];
    end

    // Outcome of the search pass.
    always_comb
    begin
        do_hit   = found_reg && !chg_reg;
        do_claim = !do_hit && cand_reg;
        target   = do_hit ? found_idx_reg : best_idx_reg;
        res_ext  = EXT_W'(target);
    end

    // Sequencer: search pass, rotate to the target slot, then deliver the word.
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        cnt_next       = cnt_reg;
        next_slot_next = next_slot_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        chg_next       = chg_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        cand_next      = cand_reg;
        best_idx_next  = best_idx_reg;
        best_gap_next  = best_gap_reg;
        out_valid_next = out_valid_reg;
        out_slot_next  = out_slot_reg;
        out_hit_next   = out_hit_reg;
        out_full_next  = out_full_reg;
        feedback       = head_entry;
        ctl.shift_en   = 1'b0;
        ctl.clear_used = 1'b0;
        in_ready       = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (opcode == OP_FRAME_END)
                    begin
                        ctl.clear_used = 1'b1;
                    end
                    else
                    begin
                        x_next     = pos_x;
                        y_next     = pos_y;
                        chg_next   = changed;
                        found_next = 1'b0;
                        cand_next  = 1'b0;
                        cnt_next   = '0;
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                ctl.shift_en    = 1'b1;
                feedback.stored = eff_stored;
                head_next       = head_inc;
                cnt_next        = cnt_reg + 1'b1;
                if (match)
                begin
                    found_next     = 1'b1;
                    found_idx_next = head_reg;
                end
                if (cand && (!cand_reg || (gap < best_gap_reg)))
                begin
                    cand_next     = 1'b1;
                    best_idx_next = head_reg;
                    best_gap_next = gap;
                end
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (!do_hit && !do_claim)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ctl.shift_en = 1'b1;
                    head_next    = head_inc;
                    if (head_reg == target)
                    begin
                        feedback.used = 1'b1;
                        if (do_claim)
                        begin
                            feedback.x      = x_reg;
                            feedback.y      = y_reg;
                            feedback.stored = 1'b1;
                            next_slot_next  = best_inc;
                        end
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_slot_next  = (do_hit || do_claim) ? res_ext[SLOT_W-1:0] : '0;
                    out_hit_next   = do_hit;
                    out_full_next  = !do_hit && !do_claim;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            cnt_reg       <= '0;
            next_slot_reg <= '0;
            found_reg     <= 1'b0;
            cand_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            cnt_reg       <= cnt_next;
            next_slot_reg <= next_slot_next;
            found_reg     <= found_next;
            cand_reg      <= cand_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        y_reg         <= y_next;
        chg_reg       <= chg_next;
        found_idx_reg <= found_idx_next;
        best_idx_reg  <= best_idx_next;
        best_gap_reg  <= best_gap_next;
        out_slot_reg  <= out_slot_next;
        out_hit_reg   <= out_hit_next;
        out_full_reg  <= out_full_next;
    end

    assign out_valid = out_valid_reg;
    assign slot      = out_slot_reg;
    assign hit       = out_hit_reg;
    assign full_res  = out_full_reg;

endmodule

`default_nettype wire

[hw/rtl/chunk_residency_cache_core.sv]
// Chunk residency cache: tracks which map chunks sit in which upload slots.
// An access word searches the slots for the chunk; on a miss it claims a slot
// round-robin, skipping slots that are stored and used this frame, and reports
// whether an upload is needed or that no slot is free. The slots form a ring of
// SLOTS cells that rotates one place per cycle, while an access shifts it, past
// a single compare point at its head. An access runs a search pass over all
// SLOTS cells, then rotates the chosen slot to the head and updates it (no
// rotation when no slot is free), then registers the result, later when the
// previous result still waits for the receiver. The next word is taken in the
// cycle after the result is registered. An end-of-frame word clears every used
// mark together and gives no result. No word is taken while an access is in
// progress; a finished result waits in the output register while the next
// word is taken.
// Depends on crc_pkg, crc_cell and crc_ctrl.
`default_nettype none

module chunk_residency_cache_core
    import crc_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               opcode,
    input  wire logic [COORD_W-1:0] pos_x,
    input  wire logic [COORD_W-1:0] pos_y,
    input  wire logic               changed,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [SLOT_W-1:0]       slot,
    output logic                    hit,
    output logic                    full_res
);

    slot_entry_t ring_q [SLOTS];
    slot_entry_t feedback;
    ring_ctl_t   ctl;

    // Head controller working on cell zero.
    crc_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .changed    (changed),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .slot       (slot),
        .hit        (hit),
        .full_res   (full_res),
        .head_entry (ring_q[0]),
        .feedback   (feedback),
        .ctl        (ctl)
    );

    // Ring of slot cells; the last cell takes the updated head entry.
    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        if (i == SLOTS - 1)
        begin : g_tail
            crc_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctl   (ctl),
                .d     (feedback),
                .q     (ring_q[i])
            );
        end
        else
        begin : g_body
            crc_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctl   (ctl),
                .d     (ring_q[i+1]),
                .q     (ring_q[i])
            );
        end
    end

endmodule

`default_nettype wire
